@@ sv/ssa_pkg.sv @@
// ----------------------------------------------------------------------------
// ssa_pkg
// Shared types and constants for the step size autotuner.
// ----------------------------------------------------------------------------
package ssa_pkg;

  localparam int unsigned HISTORY_DEF = 16;

  localparam logic [15:0] MIN_ACCEPT_RST = 16'd13107;
  localparam logic [15:0] MAX_ACCEPT_RST = 16'd26214;

  localparam logic CFG_MIN_ACCEPT = 1'b0;
  localparam logic CFG_MAX_ACCEPT = 1'b1;

  localparam logic [1:0] SRC_KEEP  = 2'd0;
  localparam logic [1:0] SRC_REGR  = 2'd1;
  localparam logic [1:0] SRC_BLIND = 2'd2;

  typedef struct packed {
    logic [31:0] step_size;
    logic [15:0] accept_rate;
    logic [15:0] random_fraction;
  } in_item_t;

  typedef struct packed {
    logic [31:0] next_step_size;
    logic [1:0]  source;
  } out_item_t;

  typedef struct packed {
    logic [15:0] accept;
    logic [31:0] step;
  } hist_entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BLIND,
    S_SUM,
    S_MUL,
    S_MWAIT,
    S_COMB,
    S_DIV,
    S_DWAIT,
    S_DONE
  } state_e;

  typedef enum logic [2:0] {
    OP_NSXX,
    OP_SXSQ,
    OP_A1,
    OP_A2,
    OP_TOT,
    OP_TERM,
    OP_DVS
  } mop_e;

endpackage

@@ sv/step_size_autotuner_unit.sv @@
// ----------------------------------------------------------------------------
// step_size_autotuner_unit
// Records (rate, step) pairs in a history ring and proposes the next step:
// kept, least-squares prediction at the band midpoint, or blind scaling.
//
//   channel   dir   handshake              payload
//   in        in    in_valid_i/in_ready_o  in_data_i  (in_item_t)
//   out       out   out_valid_o/out_ready_i out_data_o (out_item_t)
//   cfg       in    cfg_we_i               cfg_idx_i, cfg_data_i
//
// Kept items go straight to the output register; blind items pass S_BLIND
// first. A regression item walks the ring, then runs seven shift-add
// multiplies whose length follows the multiplier operand bits, then the
// serial divider. One transaction is in flight at a time; a new one is
// taken while the previous result waits in the output register.
// Reset clears control state only; ring entries are valid once written.
// ----------------------------------------------------------------------------
module step_size_autotuner_unit
  import ssa_pkg::*;
#(
  parameter int unsigned HISTORY = HISTORY_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o,
  input  logic      cfg_we_i,
  input  logic      cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned AW   = $clog2(HISTORY);
  localparam int unsigned CW   = $clog2(HISTORY + 1);
  localparam int unsigned FCW  = $clog2(HISTORY + 2);
  localparam int unsigned SXW  = 16 + AW;
  localparam int unsigned SYW  = 32 + AW;
  localparam int unsigned SXXW = 32 + AW;
  localparam int unsigned SXYW = 48 + AW;

  state_e state_q, state_d;
  mop_e   op_q;

  logic [15:0]    min_q, max_q;
  logic [FCW-1:0] fc_q;
  logic [AW-1:0]  slot_q;
  logic [31:0]    last_q;
  logic [31:0]    step_q;
  logic [15:0]    u_q;
  logic           below_q;
  logic [CW-1:0]  cnt_q;
  logic           v0_q, v1_q;
  logic [15:0]    x_q;
  logic [31:0]    y_q, xx_q;
  logic [47:0]    xy_q;
  logic [SXW-1:0]  sx_q;
  logic [SYW-1:0]  sy_q;
  logic [SXXW-1:0] sxx_q;
  logic [SXYW-1:0] sxy_q;
  logic [63:0]    nsxx_q, sx2_q, a1_q, a2_q, dvs_q;
  logic [127:0]   tot_q, term_q;
  logic [31:0]    res_q;
  logic [1:0]     src_q;
  out_item_t      out_q;
  logic           out_valid_q;

  logic        accept, early, in_band, in_below, mem_we;
  logic        issue, mul_start, div_start, out_load;
  hist_entry_t wdata, rdata;
  logic [63:0] den_w, num_mag, t1_w, t2_w, t_mag, mul_a, mul_b;
  logic        den_zero, num_neg, t_neg, same_sgn, comb_neg;
  logic [127:0] comb_w, mul_p;
  logic        mul_done, div_done;
  logic [31:0] div_q;
  logic [48:0] bl_prod;
  logic [31:0] bl_res;

  assign accept   = in_valid_i && in_ready_o;
  assign early    = fc_q < FCW'(HISTORY);
  assign in_band  = (in_data_i.accept_rate >= min_q) && (in_data_i.accept_rate <= max_q);
  assign in_below = ({in_data_i.accept_rate, 1'b0} < ({1'b0, min_q} + {1'b0, max_q}));
  assign mem_we   = accept && (early || (last_q != in_data_i.step_size));
  assign wdata    = '{accept: in_data_i.accept_rate, step: in_data_i.step_size};

  ssa_hist_mem #(.HISTORY(HISTORY)) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(slot_q),
    .wdata_i(wdata),
    .raddr_i(cnt_q[AW-1:0]),
    .rdata_o(rdata)
  );

  // regression arithmetic
  assign den_w    = nsxx_q - sx2_q;
  assign den_zero = (den_w == 64'd0);
  assign num_neg  = a1_q < a2_q;
  assign num_mag  = num_neg ? (a2_q - a1_q) : (a1_q - a2_q);
  assign t1_w     = 64'(HISTORY) * 64'({1'b0, min_q} + {1'b0, max_q});
  assign t2_w     = 64'({sx_q, 1'b0});
  assign t_neg    = t1_w < t2_w;
  assign t_mag    = t_neg ? (t2_w - t1_w) : (t1_w - t2_w);
  assign same_sgn = (num_neg == t_neg);
  assign comb_neg = !same_sgn && (tot_q < term_q);
  assign comb_w   = same_sgn ? (tot_q + term_q) : (tot_q - term_q);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op_q)
      OP_NSXX: begin mul_a = 64'(sxx_q);         mul_b = 64'(HISTORY);     end
      OP_SXSQ: begin mul_a = 64'(sx_q);          mul_b = 64'(sx_q);        end
      OP_A1:   begin mul_a = 64'(sxy_q);         mul_b = 64'(HISTORY);     end
      OP_A2:   begin mul_a = 64'(sy_q);          mul_b = 64'(sx_q);        end
      OP_TOT:  begin mul_a = 64'({sy_q, 1'b0});  mul_b = den_w;            end
      OP_TERM: begin mul_a = num_mag;            mul_b = t_mag;            end
      OP_DVS:  begin mul_a = den_w;              mul_b = 64'(2 * HISTORY); end
      default: begin mul_a = '0;                 mul_b = '0;               end
    endcase
  end

  ssa_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .p_o    (mul_p)
  );

  ssa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (tot_q),
    .den_i  (dvs_q),
    .done_o (div_done),
    .q_o    (div_q)
  );

  // blind scaling
  assign bl_prod = 49'(step_q) * 49'(17'h10000 + {1'b0, u_q});
  assign bl_res  = below_q ? bl_prod[48:17]
                           : (bl_prod[48] ? 32'hFFFF_FFFF : bl_prod[47:16]);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (early && in_band) begin
            state_d = S_DONE;
          end else if (early || !in_band) begin
            state_d = S_BLIND;
          end else begin
            state_d = S_SUM;
          end
        end
      end
      S_BLIND: state_d = S_DONE;
      S_SUM: begin
        if (!issue && !v0_q && !v1_q) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        if (op_q == OP_A1 && den_zero) begin
          state_d = S_BLIND;
        end else begin
          state_d = S_MWAIT;
        end
      end
      S_MWAIT: begin
        if (mul_done) begin
          if (op_q == OP_DVS) begin
            state_d = S_DIV;
          end else if (op_q == OP_TERM) begin
            state_d = S_COMB;
          end else begin
            state_d = S_MUL;
          end
        end
      end
      S_COMB: state_d = comb_neg ? S_BLIND : S_MUL;
      S_DIV:  state_d = S_DWAIT;
      S_DWAIT: begin
        if (div_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready_o = (state_q == S_IDLE);
    issue      = (state_q == S_SUM) && (cnt_q < CW'(HISTORY));
    mul_start  = (state_q == S_MUL) && !(op_q == OP_A1 && den_zero);
    div_start  = (state_q == S_DIV);
    out_load   = (state_q == S_DONE) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      min_q       <= MIN_ACCEPT_RST;
      max_q       <= MAX_ACCEPT_RST;
      fc_q        <= '0;
      slot_q      <= '0;
      last_q      <= '0;
      cnt_q       <= '0;
      v0_q        <= 1'b0;
      v1_q        <= 1'b0;
      op_q        <= OP_NSXX;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MIN_ACCEPT: min_q <= cfg_data_i;
          CFG_MAX_ACCEPT: max_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) begin
        slot_q <= (slot_q == AW'(HISTORY - 1)) ? '0 : slot_q + 1'b1;
        last_q <= in_data_i.step_size;
        if (fc_q < FCW'(HISTORY + 1)) begin
          fc_q <= fc_q + 1'b1;
        end
        cnt_q <= '0;
        op_q  <= OP_NSXX;
      end
      if (issue) begin
        cnt_q <= cnt_q + 1'b1;
      end
      v0_q <= issue;
      v1_q <= v0_q;
      if (state_q == S_MWAIT && mul_done && op_q != OP_DVS && op_q != OP_TERM) begin
        op_q <= mop_e'(op_q + 3'd1);
      end
      if (state_q == S_COMB) begin
        op_q <= OP_DVS;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      step_q  <= in_data_i.step_size;
      u_q     <= in_data_i.random_fraction;
      below_q <= in_below;
      res_q   <= in_data_i.step_size;
      src_q   <= SRC_KEEP;
      sx_q    <= '0;
      sy_q    <= '0;
      sxx_q   <= '0;
      sxy_q   <= '0;
    end
    if (v0_q) begin
      x_q  <= rdata.accept;
      y_q  <= rdata.step;
      xx_q <= 32'(rdata.accept) * 32'(rdata.accept);
      xy_q <= 48'(rdata.accept) * 48'(rdata.step);
    end
    if (v1_q) begin
      sx_q  <= sx_q + SXW'(x_q);
      sy_q  <= sy_q + SYW'(y_q);
      sxx_q <= sxx_q + SXXW'(xx_q);
      sxy_q <= sxy_q + SXYW'(xy_q);
    end
    if (state_q == S_MWAIT && mul_done) begin
      case (op_q)
        OP_NSXX: nsxx_q <= mul_p[63:0];
        OP_SXSQ: sx2_q  <= mul_p[63:0];
        OP_A1:   a1_q   <= mul_p[63:0];
        OP_A2:   a2_q   <= mul_p[63:0];
        OP_TOT:  tot_q  <= mul_p;
        OP_TERM: term_q <= mul_p;
        OP_DVS:  dvs_q  <= mul_p[63:0];
        default: ;
      endcase
    end
    if (state_q == S_COMB) begin
      tot_q <= comb_w;
    end
    if (state_q == S_BLIND) begin
      res_q <= bl_res;
      src_q <= SRC_BLIND;
    end
    if (state_q == S_DWAIT && div_done) begin
      res_q <= div_q;
      src_q <= SRC_REGR;
    end
    if (out_load) begin
      out_q.next_step_size <= res_q;
      out_q.source         <= src_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != S_IDLE))
    else $error("accepted transaction did not start processing");

  a_regr_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SUM) |-> (fc_q == FCW'(HISTORY + 1)))
    else $error("regression started before ring overflow");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_valid_q && !out_ready_i) |=> (state_q == S_DONE))
    else $error("result overwrote a pending output");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(slot_q) < HISTORY)
    else $error("write slot out of range");

endmodule

@@ sv/ssa_hist_mem.sv @@
// ----------------------------------------------------------------------------
// ssa_hist_mem
// History ring storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ssa_hist_mem
  import ssa_pkg::*;
#(
  parameter int unsigned HISTORY = HISTORY_DEF
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(HISTORY)-1:0] waddr_i,
  input  hist_entry_t                wdata_i,
  input  logic [$clog2(HISTORY)-1:0] raddr_i,
  output hist_entry_t                rdata_o
);

  hist_entry_t mem_q [HISTORY];
  hist_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/ssa_mul.sv @@
// ----------------------------------------------------------------------------
// ssa_mul
// Shift-add multiplier, 64 x 64 -> 128, one multiplier bit per cycle,
// stops once the remaining multiplier bits are zero.
// ----------------------------------------------------------------------------
module ssa_mul
  import ssa_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [63:0]  a_i,
  input  logic [63:0]  b_i,
  output logic         done_o,
  output logic [127:0] p_o
);

  logic         busy_q, done_q;
  logic [127:0] acc_q, a_q;
  logic [63:0]  b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && (b_q == 64'd0)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      a_q   <= {64'd0, a_i};
      b_q   <= b_i;
    end else if (busy_q && (b_q != 64'd0)) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= {a_q[126:0], 1'b0};
      b_q <= {1'b0, b_q[63:1]};
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

@@ sv/ssa_div.sv @@
// ----------------------------------------------------------------------------
// ssa_div
// Restoring divider, 128 / 64, one quotient bit per cycle; quotient
// saturates to 32 bits.
// ----------------------------------------------------------------------------
module ssa_div
  import ssa_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [127:0] num_i,
  input  logic [63:0]  den_i,
  output logic         done_o,
  output logic [31:0]  q_o
);

  logic         busy_q, done_q;
  logic [6:0]   cnt_q;
  logic [127:0] num_q;
  logic [63:0]  den_q, rem_q;
  logic [31:0]  quo_q;
  logic         ovf_q;
  logic [63:0]  trial;
  logic         fits;

  assign trial = {rem_q[62:0], num_q[127]};
  assign fits  = (trial >= den_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q == 7'd127) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
      ovf_q <= 1'b0;
    end else if (busy_q) begin
      rem_q <= fits ? (trial - den_q) : trial;
      num_q <= {num_q[126:0], 1'b0};
      quo_q <= {quo_q[30:0], fits};
      ovf_q <= ovf_q | quo_q[31];
    end
  end

  assign done_o = done_q;
  assign q_o    = ovf_q ? 32'hFFFF_FFFF : quo_q;

endmodule
